### rtl/obb_overlap_test_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the oriented box overlap core
// Implication checks, same cycle and next cycle, with reset disable.
// ----------------------------------------------------------------------------
`ifndef OBB_OVERLAP_TEST_CORE_MACROS_SVH
`define OBB_OVERLAP_TEST_CORE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define OBB_ASSERT_IMP(LBL, CLK, RSTN, ANTE, CONS, MSG) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
        else $error(MSG);

// consequent must hold in the cycle after the antecedent
`define OBB_ASSERT_NXT(LBL, CLK, RSTN, ANTE, CONS, MSG) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
        else $error(MSG);

`endif

### rtl/obb_pkg.sv
// ----------------------------------------------------------------------------
// Oriented box overlap package
// Widths, codes, the row request type and small helper functions.
// ----------------------------------------------------------------------------
package obb_pkg;

    localparam int IN_W         = 32;
    localparam int CW           = 32;   // stored coordinate width
    localparam int FRAC         = 16;   // fraction bits
    localparam int ROW_W        = 3 * CW;
    localparam int ROWS_PER_BOX = 5;
    localparam int STORE_ROWS   = 2 * ROWS_PER_BOX;
    localparam int ROW_ADDR_W   = $clog2(STORE_ROWS);
    localparam int EXT_N        = 18;
    localparam int EXT_ADDR_W   = $clog2(EXT_N);
    localparam int D_W          = CW + 1;
    localparam int EXT_W        = 2 * CW;
    localparam int MA_W         = 2 * CW;
    localparam int L_W          = 2 * CW + 1;
    localparam int P_W          = MA_W + L_W;
    localparam int MCNT_W       = $clog2(L_W + 1);
    localparam int ACC_W        = P_W + 2;
    localparam int CMP_W        = ACC_W + FRAC + 3;
    localparam int AXIS_W       = 5;
    localparam int QDEPTH       = 2;
    localparam int QPTR_W       = $clog2(QDEPTH);
    localparam int QCNT_W       = $clog2(QDEPTH + 1);

    localparam logic [2:0] ROW_CENTER = 3'd0;
    localparam logic [2:0] ROW_AX0    = 3'd1;
    localparam logic [2:0] ROW_HALF   = 3'd4;

    localparam logic [AXIS_W-1:0] AX_LAST_FACE   = AXIS_W'(5);
    localparam logic [AXIS_W-1:0] AX_FIRST_CROSS = AXIS_W'(6);
    localparam logic [AXIS_W-1:0] AX_PARALLEL    = AXIS_W'(15);
    localparam logic [AXIS_W-1:0] AX_NONE        = AXIS_W'(16);

    localparam logic [1:0] COMP_LAST = 2'd2;
    localparam logic [2:0] TERM_LAST = 3'd6;

    typedef struct packed {
        logic                  store_en;
        logic [ROW_ADDR_W-1:0] row_addr;
        logic [ROW_W-1:0]      row_data;
        logic                  run;
    } req_t;

    function automatic logic [ROW_ADDR_W-1:0] row_addr_of(input logic box,
                                                          input logic [2:0] row);
        return box ? ROW_ADDR_W'(ROWS_PER_BOX) + ROW_ADDR_W'(row) : ROW_ADDR_W'(row);
    endfunction

    function automatic logic signed [CW-1:0] to_coord(input logic signed [IN_W-1:0] v);
        return CW'(v);
    endfunction

    function automatic logic signed [CW-1:0] coord_of(input logic [ROW_W-1:0] row,
                                                      input logic [1:0] c);
        logic signed [CW-1:0] r;
        case (c)
            2'd0:    r = row[CW-1:0];
            2'd1:    r = row[2*CW-1:CW];
            2'd2:    r = row[3*CW-1:2*CW];
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] rot1(input logic [1:0] c);
        logic [1:0] r;
        case (c)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] rot2(input logic [1:0] c);
        logic [1:0] r;
        case (c)
            2'd0:    r = 2'd2;
            2'd1:    r = 2'd0;
            default: r = 2'd1;
        endcase
        return r;
    endfunction

endpackage

### rtl/obb_front.sv
// ----------------------------------------------------------------------------
// Row front end
// Classifies incoming rows and holds them in a short request queue.
// ----------------------------------------------------------------------------
module obb_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic                             box_select,
    input  logic [2:0]                       row_index,
    input  logic signed [obb_pkg::IN_W-1:0]  value_x,
    input  logic signed [obb_pkg::IN_W-1:0]  value_y,
    input  logic signed [obb_pkg::IN_W-1:0]  value_z,
    input  logic                             run_test,
    output logic                             req_valid,
    output obb_pkg::req_t                    req,
    input  logic                             req_pop
);
    import obb_pkg::*;

    req_t              q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    req_t              in_req;
    logic              do_push;
    logic              do_pop;

    always_comb
    begin
        in_req.store_en = (row_index <= ROW_HALF);
        in_req.row_addr = row_addr_of(box_select, row_index);
        in_req.row_data = {to_coord(value_z), to_coord(value_y), to_coord(value_x)};
        in_req.run      = run_test;
    end

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign req_valid = (count_reg != '0);
    assign req       = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = req_pop && req_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wr_ptr_reg] <= in_req;
    end

endmodule

### rtl/obb_mul.sv
// ----------------------------------------------------------------------------
// Shift-add multiplier
// Signed multiply, one multiplier bit per cycle on the magnitudes.
// ----------------------------------------------------------------------------
module obb_mul (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic signed [obb_pkg::MA_W-1:0] a,
    input  logic signed [obb_pkg::L_W-1:0]  b,
    output logic                            done,
    output logic signed [obb_pkg::P_W-1:0]  p
);
    import obb_pkg::*;

    logic              busy_reg;
    logic              fix_reg;
    logic              done_reg;
    logic [MCNT_W-1:0] cnt_reg;
    logic [P_W-1:0]    mcand_reg;
    logic [L_W-1:0]    mplier_reg;
    logic [P_W-1:0]    acc_reg;
    logic              neg_reg;
    logic signed [P_W-1:0] p_reg;
    logic [MA_W-1:0]   abs_a;
    logic [L_W-1:0]    abs_b;

    assign abs_a = a[MA_W-1] ? (~a + 1'b1) : a;
    assign abs_b = b[L_W-1] ? (~b + 1'b1) : b;
    assign done  = done_reg;
    assign p     = p_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MCNT_W'(L_W - 1))
                begin
                    busy_reg <= 1'b0;
                    fix_reg  <= 1'b1;
                end
            end
            else if (fix_reg)
            begin
                fix_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= P_W'(abs_a);
            mplier_reg <= abs_b;
            acc_reg    <= '0;
            neg_reg    <= a[MA_W-1] ^ b[L_W-1];
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
                acc_reg <= acc_reg + mcand_reg;
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
        else if (fix_reg)
        begin
            // apply the sign once the magnitude is complete
            p_reg <= neg_reg ? $signed(~acc_reg + 1'b1) : $signed(acc_reg);
        end
    end

endmodule

### rtl/obb_back.sv
// ----------------------------------------------------------------------------
// Test back end
// Box row store, axis sequencer over the shared multiplier, result register.
// ----------------------------------------------------------------------------
`include "obb_overlap_test_core_macros.svh"

module obb_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    input  obb_pkg::req_t                  req,
    output logic                           req_pop,
    output logic                           empty,
    input  logic                           pop,
    output logic                           overlap,
    output logic [obb_pkg::AXIS_W-1:0]     deciding_axis
);
    import obb_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FETCH = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;
    localparam logic [2:0] ST_ABS   = 3'd4;
    localparam logic [2:0] ST_SUM   = 3'd5;
    localparam logic [2:0] ST_CMP   = 3'd6;

    localparam logic [2:0] PH_EXT    = 3'd0;
    localparam logic [2:0] PH_D      = 3'd1;
    localparam logic [2:0] PH_LFACE  = 3'd2;
    localparam logic [2:0] PH_LCROSS = 3'd3;
    localparam logic [2:0] PH_DOT    = 3'd4;
    localparam logic [2:0] PH_PAR    = 3'd5;

    logic [2:0]        state_reg;
    logic [2:0]        phase_reg;
    logic              b_reg;
    logic [1:0]        k_reg;
    logic [1:0]        c_reg;
    logic              s_reg;
    logic [2:0]        t_reg;
    logic [1:0]        i_reg;
    logic [1:0]        j_reg;
    logic [AXIS_W-1:0] n_reg;
    logic              res_valid_reg;
    logic              res_overlap_reg;
    logic [AXIS_W-1:0] res_axis_reg;

    logic [ROW_W-1:0]      store_mem [STORE_ROWS];
    logic [ROW_W-1:0]      row_a_reg;
    logic [ROW_W-1:0]      row_b_reg;
    logic [ROW_ADDR_W-1:0] addr_a;
    logic [ROW_ADDR_W-1:0] addr_b;
    logic [EXT_W-1:0]      ext_mem [EXT_N];
    logic [EXT_W-1:0]      ext_rd_reg;
    logic [EXT_ADDR_W-1:0] ext_rd_addr;
    logic [EXT_ADDR_W-1:0] ext_wr_addr;

    logic signed [D_W-1:0]   d_reg [3];
    logic signed [L_W-1:0]   l_reg [3];
    logic signed [EXT_W-1:0] tmp_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0]        mag_reg;
    logic [CMP_W-1:0]        lhs_reg;
    logic [CMP_W-1:0]        rhs_reg;

    logic                    mul_start;
    logic                    mul_done;
    logic signed [MA_W-1:0]  mul_a;
    logic signed [L_W-1:0]   mul_b;
    logic signed [P_W-1:0]   mul_p;

    logic                    store_we;
    logic                    ext_we;
    logic                    last_ext;
    logic                    pair_last;
    logic                    sep;
    logic                    row_eq;
    logic signed [ACC_W-1:0] dot_sum;

    obb_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    assign req_pop   = (state_reg == ST_IDLE) && req_valid && (!req.run || !res_valid_reg);
    assign store_we  = req_pop && req.store_en;
    assign ext_we    = (state_reg == ST_WAIT) && mul_done && (phase_reg == PH_EXT);
    assign mul_start = (state_reg == ST_START) &&
                       ((phase_reg == PH_EXT) || (phase_reg == PH_LCROSS) ||
                        (phase_reg == PH_DOT));
    assign last_ext  = b_reg && (k_reg == COMP_LAST) && (c_reg == COMP_LAST);
    assign pair_last = (i_reg == COMP_LAST) && (j_reg == COMP_LAST);
    assign sep       = lhs_reg > rhs_reg;
    assign row_eq    = row_a_reg == row_b_reg;
    assign dot_sum   = acc_reg + ACC_W'(mul_p);
    assign ext_wr_addr = EXT_ADDR_W'(9 * b_reg + 3 * k_reg + c_reg);

    assign empty         = !res_valid_reg;
    assign overlap       = res_overlap_reg;
    assign deciding_axis = res_axis_reg;

    always_comb
    begin
        addr_a      = '0;
        addr_b      = '0;
        ext_rd_addr = (t_reg == '0) ? '0 : EXT_ADDR_W'(3 * (t_reg - 3'd1) + c_reg);
        case (phase_reg)
            PH_EXT:
            begin
                addr_a = row_addr_of(b_reg, 3'(k_reg) + ROW_AX0);
                addr_b = row_addr_of(b_reg, ROW_HALF);
            end
            PH_D:
            begin
                addr_a = row_addr_of(1'b0, ROW_CENTER);
                addr_b = row_addr_of(1'b1, ROW_CENTER);
            end
            PH_LFACE:
                addr_a = row_addr_of(n_reg[0], 3'(n_reg[2:1]) + ROW_AX0);
            PH_LCROSS, PH_PAR:
            begin
                addr_a = row_addr_of(1'b0, 3'(i_reg) + ROW_AX0);
                addr_b = row_addr_of(1'b1, 3'(j_reg) + ROW_AX0);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (phase_reg)
            PH_EXT:
            begin
                mul_a = MA_W'(coord_of(row_a_reg, c_reg));
                mul_b = L_W'(coord_of(row_b_reg, k_reg));
            end
            PH_LCROSS:
            begin
                if (!s_reg)
                begin
                    mul_a = MA_W'(coord_of(row_a_reg, rot1(c_reg)));
                    mul_b = L_W'(coord_of(row_b_reg, rot2(c_reg)));
                end
                else
                begin
                    mul_a = MA_W'(coord_of(row_a_reg, rot2(c_reg)));
                    mul_b = L_W'(coord_of(row_b_reg, rot1(c_reg)));
                end
            end
            PH_DOT:
            begin
                mul_a = (t_reg == '0) ? MA_W'(d_reg[c_reg]) : $signed(ext_rd_reg);
                mul_b = l_reg[c_reg];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
            store_mem[req.row_addr] <= req.row_data;
        row_a_reg <= store_mem[addr_a];
        row_b_reg <= store_mem[addr_b];
        if (ext_we)
            ext_mem[ext_wr_addr] <= mul_p[EXT_W-1:0];
        ext_rd_reg <= ext_mem[ext_rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_EXT;
            b_reg         <= 1'b0;
            k_reg         <= '0;
            c_reg         <= '0;
            s_reg         <= 1'b0;
            t_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            n_reg         <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && res_valid_reg)
                res_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (req_pop && req.run)
                    begin
                        phase_reg <= PH_EXT;
                        b_reg     <= 1'b0;
                        k_reg     <= '0;
                        c_reg     <= '0;
                        state_reg <= ST_FETCH;
                    end
                end
                ST_FETCH:
                    state_reg <= ST_START;
                ST_START:
                begin
                    case (phase_reg)
                        PH_D:
                        begin
                            phase_reg <= PH_LFACE;
                            n_reg     <= '0;
                            state_reg <= ST_FETCH;
                        end
                        PH_LFACE:
                        begin
                            phase_reg <= PH_DOT;
                            t_reg     <= '0;
                            c_reg     <= '0;
                            state_reg <= ST_FETCH;
                        end
                        PH_PAR:
                        begin
                            if (row_eq)
                            begin
                                res_valid_reg <= 1'b1;
                                state_reg     <= ST_IDLE;
                            end
                            else if (pair_last)
                            begin
                                phase_reg <= PH_LCROSS;
                                n_reg     <= AX_FIRST_CROSS;
                                i_reg     <= '0;
                                j_reg     <= '0;
                                c_reg     <= '0;
                                s_reg     <= 1'b0;
                                state_reg <= ST_FETCH;
                            end
                            else
                            begin
                                if (j_reg == COMP_LAST)
                                begin
                                    j_reg <= '0;
                                    i_reg <= i_reg + 1'b1;
                                end
                                else
                                    j_reg <= j_reg + 1'b1;
                                state_reg <= ST_FETCH;
                            end
                        end
                        default:
                            state_reg <= ST_WAIT;
                    endcase
                end
                ST_WAIT:
                begin
                    if (mul_done)
                    begin
                        case (phase_reg)
                            PH_EXT:
                            begin
                                if (last_ext)
                                    phase_reg <= PH_D;
                                else if (c_reg != COMP_LAST)
                                    c_reg <= c_reg + 1'b1;
                                else
                                begin
                                    c_reg <= '0;
                                    if (k_reg == COMP_LAST)
                                    begin
                                        k_reg <= '0;
                                        b_reg <= 1'b1;
                                    end
                                    else
                                        k_reg <= k_reg + 1'b1;
                                end
                                state_reg <= ST_FETCH;
                            end
                            PH_LCROSS:
                            begin
                                s_reg <= !s_reg;
                                if (s_reg)
                                begin
                                    if (c_reg == COMP_LAST)
                                    begin
                                        phase_reg <= PH_DOT;
                                        t_reg     <= '0;
                                        c_reg     <= '0;
                                    end
                                    else
                                        c_reg <= c_reg + 1'b1;
                                end
                                state_reg <= ST_FETCH;
                            end
                            default:
                            begin
                                if (c_reg == COMP_LAST)
                                begin
                                    c_reg     <= '0;
                                    state_reg <= ST_ABS;
                                end
                                else
                                begin
                                    c_reg     <= c_reg + 1'b1;
                                    state_reg <= ST_FETCH;
                                end
                            end
                        endcase
                    end
                end
                ST_ABS:
                    state_reg <= ST_SUM;
                ST_SUM:
                begin
                    if (t_reg == TERM_LAST)
                        state_reg <= ST_CMP;
                    else
                    begin
                        t_reg     <= t_reg + 1'b1;
                        state_reg <= ST_FETCH;
                    end
                end
                ST_CMP:
                begin
                    if (sep)
                    begin
                        res_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                    else if (n_reg < AX_LAST_FACE)
                    begin
                        n_reg     <= n_reg + 1'b1;
                        phase_reg <= PH_LFACE;
                        state_reg <= ST_FETCH;
                    end
                    else if (n_reg == AX_LAST_FACE)
                    begin
                        // face axes exhausted: try the parallel shortcut
                        phase_reg <= PH_PAR;
                        i_reg     <= '0;
                        j_reg     <= '0;
                        state_reg <= ST_FETCH;
                    end
                    else if (pair_last)
                    begin
                        res_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                    else
                    begin
                        if (j_reg == COMP_LAST)
                        begin
                            j_reg <= '0;
                            i_reg <= i_reg + 1'b1;
                        end
                        else
                            j_reg <= j_reg + 1'b1;
                        n_reg     <= n_reg + 1'b1;
                        phase_reg <= PH_LCROSS;
                        c_reg     <= '0;
                        s_reg     <= 1'b0;
                        state_reg <= ST_FETCH;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                acc_reg <= '0;
            ST_START:
            begin
                case (phase_reg)
                    PH_D:
                        for (int q = 0; q < 3; q++)
                            d_reg[q] <= D_W'(coord_of(row_b_reg, 2'(q))) -
                                        D_W'(coord_of(row_a_reg, 2'(q)));
                    PH_LFACE:
                        for (int q = 0; q < 3; q++)
                            l_reg[q] <= L_W'(coord_of(row_a_reg, 2'(q)));
                    PH_PAR:
                    begin
                        if (row_eq)
                        begin
                            res_overlap_reg <= 1'b1;
                            res_axis_reg    <= AX_PARALLEL;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_WAIT:
            begin
                if (mul_done)
                begin
                    case (phase_reg)
                        PH_LCROSS:
                        begin
                            if (!s_reg)
                                tmp_reg <= mul_p[EXT_W-1:0];
                            else
                                l_reg[c_reg] <= L_W'(tmp_reg) -
                                                L_W'($signed(mul_p[EXT_W-1:0]));
                        end
                        PH_DOT:
                            acc_reg <= dot_sum;
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_ABS:
            begin
                mag_reg <= acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
                acc_reg <= '0;
            end
            ST_SUM:
            begin
                // centre term scales by the fraction, box terms accumulate
                if (t_reg == '0)
                begin
                    lhs_reg <= CMP_W'(mag_reg) << FRAC;
                    rhs_reg <= '0;
                end
                else
                    rhs_reg <= rhs_reg + CMP_W'(mag_reg);
            end
            ST_CMP:
            begin
                if (sep)
                begin
                    res_overlap_reg <= 1'b0;
                    res_axis_reg    <= n_reg;
                end
                else if ((n_reg > AX_LAST_FACE) && pair_last)
                begin
                    res_overlap_reg <= 1'b1;
                    res_axis_reg    <= AX_NONE;
                end
            end
            default:
            begin
            end
        endcase
    end

    `OBB_ASSERT_IMP(a_busy_slot_free, clk, rst_n, state_reg != ST_IDLE, !res_valid_reg, "test running while a result waits")
    `OBB_ASSERT_IMP(a_done_in_wait, clk, rst_n, mul_done, state_reg == ST_WAIT, "product arrived outside the wait state")
    `OBB_ASSERT_IMP(a_run_needs_slot, clk, rst_n, req_pop && req.run, !res_valid_reg, "test request taken with result slot full")
    `OBB_ASSERT_NXT(a_pop_clears, clk, rst_n, pop && res_valid_reg, !res_valid_reg, "result still shown after it was taken")

endmodule

### rtl/obb_overlap_test_core.sv
// ----------------------------------------------------------------------------
// Oriented box overlap test core
// Separating axis test between two boxes loaded row by row.
// ----------------------------------------------------------------------------
// Rows are queued and stored at one per cycle while no test runs. A row with
// run_test set starts the test once the result register is free; the test
// runs up to 387 signed multiplies, all on the single shared shift-add
// multiplier that retires one bit of its 65-bit operand per cycle. Rows keep
// queueing behind a running test, and a finished result waits on the result
// side until popped while further rows are taken.
module obb_overlap_test_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic                             box_select,
    input  logic [2:0]                       row_index,
    input  logic signed [obb_pkg::IN_W-1:0]  value_x,
    input  logic signed [obb_pkg::IN_W-1:0]  value_y,
    input  logic signed [obb_pkg::IN_W-1:0]  value_z,
    input  logic                             run_test,
    output logic                             empty,
    input  logic                             pop,
    output logic                             overlap,
    output logic [obb_pkg::AXIS_W-1:0]       deciding_axis
);
    import obb_pkg::*;

    req_t req;
    logic req_valid;
    logic req_pop;

    obb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .box_select (box_select),
        .row_index  (row_index),
        .value_x    (value_x),
        .value_y    (value_y),
        .value_z    (value_z),
        .run_test   (run_test),
        .req_valid  (req_valid),
        .req        (req),
        .req_pop    (req_pop)
    );

    obb_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req           (req),
        .req_pop       (req_pop),
        .empty         (empty),
        .pop           (pop),
        .overlap       (overlap),
        .deciding_axis (deciding_axis)
    );

endmodule
